// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== src/dmbk_pkg.sv =====
// ----------------------------------------------------------------------------
// dmbk_pkg
// Types, constants and commands of the best-k descriptor matcher.
// ----------------------------------------------------------------------------
package dmbk_pkg;
   localparam int DESC_LEN_DEF   = 128;
   localparam int KEEP_PAIRS_DEF = 9;
   localparam int MAX_RIGHT_DEF  = 1024;

   localparam int CMD_W  = 2;
   localparam int ELEM_W = 8;
   localparam int LEFT_W = 16;
   localparam int RNUM_W = 10;
   localparam int DIST_W = 23;

   localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_EMIT  = 2'd3;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ELEM_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [LEFT_W-1:0] left_number;
      logic [RNUM_W-1:0] right_number;
      logic [DIST_W-1:0] distance;
      logic              pair_valid;
      logic              final_pair;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clear;       // reset all counters and kept list
      logic store_elem;  // write req element (right or left)
      logic srch_start;  // begin nearest search
      logic srch_step;   // advance search one element
      logic update;      // record search result in kept list
      logic emit_start;  // load slot pointer
      logic emit_load;   // latch current slot into output reg
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic left_done;   // stored element completed a left descriptor
      logic srch_last;   // last search step issued
      logic emit_last;   // current slot is the last one
   } sts_type;
endpackage

// ===== src/dmbk_if.sv =====
// ----------------------------------------------------------------------------
// dmbk_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface dmbk_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/dmbk_ram.sv =====
// ----------------------------------------------------------------------------
// dmbk_ram
// Dual-port RAM, one write port and one read port, with registered read.
// ----------------------------------------------------------------------------
module dmbk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ===== src/dmbk_datapath.sv =====
// ----------------------------------------------------------------------------
// dmbk_datapath
// Stores, SSD accumulator, exclusion check and kept-pair list.
// ----------------------------------------------------------------------------
module dmbk_datapath import dmbk_pkg::*; #(
   parameter int DESC_LEN   = DESC_LEN_DEF,
   parameter int KEEP_PAIRS = KEEP_PAIRS_DEF,
   parameter int MAX_RIGHT  = MAX_RIGHT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req,
   output rsp_type rsp
);
   localparam int PW  = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
   localparam int RW  = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
   localparam int RCW = $clog2(MAX_RIGHT + 1);
   localparam int KW  = (KEEP_PAIRS > 1) ? $clog2(KEEP_PAIRS) : 1;
   localparam int KCW = $clog2(KEEP_PAIRS + 1);
   localparam int SW  = DIST_W + 1;
   localparam int AW  = $clog2(MAX_RIGHT * DESC_LEN);
   localparam int LPW = $clog2(DESC_LEN);

   logic [PW-1:0]  pos_ff, pos_in;
   logic [RCW-1:0] rcount_ff, rcount_in;
   logic [LEFT_W-1:0] lcount_ff, lcount_in;
   logic [KCW-1:0] kcount_ff, kcount_in;
   logic [LEFT_W-1:0] kl_ff [KEEP_PAIRS];
   logic [RW-1:0]     kr_ff [KEEP_PAIRS];
   logic [DIST_W-1:0] kd_ff [KEEP_PAIRS];

   // search state: candidate j, element i, pipeline valid/last flags
   logic [RCW-1:0] cand_ff;
   logic [PW-1:0]  ei_ff;
   logic           p1_ff, p1_first_ff, p1_end_ff;
   logic [RCW-1:0] p1_cand_ff;
   logic           p2_ff, p2_first_ff, p2_end_ff;
   logic [RCW-1:0] p2_cand_ff;
   logic [8:0]     diff_ff;
   logic [SW-1:0]  acc_ff;
   logic           found_ff;
   logic [RW-1:0]  best_ff;
   logic [DIST_W-1:0] bestd_ff;
   logic [KW-1:0]  slot_ff;
   rsp_type        rsp_ff;

   logic at_end;
   assign at_end = ({{(32-PW){1'b0}}, pos_ff} == DESC_LEN - 1);

   wire is_right = (req.command == CMD_RIGHT);
   wire rfull    = ({{(32-RCW){1'b0}}, rcount_ff} >= MAX_RIGHT);
   wire rwe      = cmd.store_elem && is_right && !rfull;
   wire lwe      = cmd.store_elem && !is_right;

   // right store
   logic [AW-1:0] rwaddr, rraddr;
   logic [ELEM_W-1:0] rdata, ldata;
   logic [AW+RCW-1:0] wa_full, ra_full;
   assign wa_full = rcount_ff * (AW+RCW)'(DESC_LEN) + (AW+RCW)'(pos_ff);
   assign ra_full = cand_ff * (AW+RCW)'(DESC_LEN) + (AW+RCW)'(ei_ff);
   assign rwaddr = wa_full[AW-1:0];
   assign rraddr = ra_full[AW-1:0];
   dmbk_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_RIGHT*DESC_LEN)) u_rstore (
      .clock(clock), .we(rwe), .waddr(rwaddr), .wdata(req.element_value),
      .raddr(rraddr), .rdata(rdata));
   dmbk_ram #(.WIDTH(ELEM_W), .DEPTH(DESC_LEN)) u_lbuf (
      .clock(clock), .we(lwe), .waddr(pos_ff[LPW-1:0]), .wdata(req.element_value),
      .raddr(ei_ff[LPW-1:0]), .rdata(ldata));

   // exclusion of current candidate
   logic excl;
   always_comb begin
      excl = 1'b0;
      for (int k = 0; k < KEEP_PAIRS; k++)
         if (k < kcount_ff && {{(RCW-RW){1'b0}}, kr_ff[k]} == cand_ff) excl = 1'b1;
   end
   wire cand_valid = (cand_ff < rcount_ff) && !excl;
   wire last_cand  = (cand_ff + 1'b1 >= rcount_ff);
   wire at_end_e = ({{(32-PW){1'b0}}, ei_ff} == DESC_LEN - 1);
   // a skipped last candidate also ends the sweep
   assign sts.srch_last = cmd.srch_step && (at_end_e || !cand_valid) && last_cand;
   assign sts.left_done = lwe && at_end;
   assign sts.emit_last = ({{(32-KW){1'b0}}, slot_ff} == KEEP_PAIRS - 1);
   assign rsp = rsp_ff;

   // pick max kept slot
   logic [KW-1:0] mslot;
   always_comb begin
      mslot = '0;
      for (int k = 1; k < KEEP_PAIRS; k++)
         if (kd_ff[k] > kd_ff[mslot]) mslot = KW'(k);
   end

   logic [SW-1:0] acc_sum;
   logic [DIST_W-1:0] acc_sat;
   logic [17:0] sq;
   assign sq = $signed(diff_ff) * $signed(diff_ff);
   assign acc_sum = (p2_first_ff ? '0 : acc_ff) + SW'(sq);
   assign acc_sat = acc_sum[SW-1] ? DIST_MAX : acc_sum[DIST_W-1:0];

   always_comb begin
      pos_in = pos_ff;
      rcount_in = rcount_ff;
      lcount_in = lcount_ff;
      if (rwe || lwe) begin
         pos_in = at_end ? '0 : pos_ff + 1'b1;
         if (rwe && at_end) rcount_in = rcount_ff + 1'b1;
      end
      if (cmd.update) lcount_in = lcount_ff + 1'b1;
   end
   assign kcount_in = (cmd.update && found_ff &&
                       {{(32-KCW){1'b0}}, kcount_ff} < KEEP_PAIRS) ?
                      kcount_ff + 1'b1 : kcount_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff <= '0; rcount_ff <= '0; lcount_ff <= '0; kcount_ff <= '0;
         p1_ff <= 1'b0; p2_ff <= 1'b0; found_ff <= 1'b0;
         for (int k = 0; k < KEEP_PAIRS; k++) begin
            kl_ff[k] <= '0; kr_ff[k] <= '0; kd_ff[k] <= '0;
         end
      end else begin
         pos_ff <= pos_in; rcount_ff <= rcount_in; lcount_ff <= lcount_in;
         kcount_ff <= kcount_in;
         // read stage: RAM data valid next cycle
         p1_ff <= cmd.srch_step && cand_valid;
         p1_first_ff <= (ei_ff == '0);
         p1_end_ff <= at_end_e;
         p1_cand_ff <= cand_ff;
         p2_ff <= p1_ff; p2_first_ff <= p1_first_ff; p2_end_ff <= p1_end_ff;
         p2_cand_ff <= p1_cand_ff;
         diff_ff <= {1'b0, ldata} - {1'b0, rdata};
         if (cmd.srch_start) found_ff <= 1'b0;
         if (p2_ff) begin
            acc_ff <= {1'b0, acc_sat};
            if (p2_end_ff && (!found_ff || acc_sat < bestd_ff)) begin
               found_ff <= 1'b1;
               best_ff <= p2_cand_ff[RW-1:0];
               bestd_ff <= acc_sat;
            end
         end
         if (cmd.update && found_ff) begin
            if ({{(32-KCW){1'b0}}, kcount_ff} < KEEP_PAIRS) begin
               kl_ff[kcount_ff[KW-1:0]] <= lcount_ff;
               kr_ff[kcount_ff[KW-1:0]] <= best_ff;
               kd_ff[kcount_ff[KW-1:0]] <= bestd_ff;
            end else if (bestd_ff < kd_ff[mslot]) begin
               kl_ff[mslot] <= lcount_ff; kr_ff[mslot] <= best_ff;
               kd_ff[mslot] <= bestd_ff;
            end
         end
      end
   end

   // candidate/element sweep and emit registers
   always_ff @(posedge clock) begin
      if (cmd.srch_start) begin
         cand_ff <= '0; ei_ff <= '0;
      end else if (cmd.srch_step) begin
         // skip excluded or absent candidates with a single search step
         if (!cand_valid || at_end_e) begin
            ei_ff <= '0; cand_ff <= cand_ff + 1'b1;
         end else ei_ff <= ei_ff + 1'b1;
      end
      if (cmd.emit_start) slot_ff <= '0;
      else if (cmd.emit_load) slot_ff <= slot_ff + 1'b1;
      if (cmd.emit_load) begin
         logic v;
         v = (KCW'(slot_ff) < kcount_ff);
         rsp_ff.left_number  <= v ? kl_ff[slot_ff] : '0;
         rsp_ff.right_number <= v ? RNUM_W'(kr_ff[slot_ff]) : '0;
         rsp_ff.distance     <= v ? kd_ff[slot_ff] : '0;
         rsp_ff.pair_valid   <= v;
         rsp_ff.final_pair   <= sts.emit_last;
      end
   end
endmodule

// ===== src/dmbk_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmbk_ctrl
// Sequencer for request handling, nearest search and emit run.
// ----------------------------------------------------------------------------
module dmbk_ctrl import dmbk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;
   localparam logic [2:0] S_DRN1 = 3'd2;
   localparam logic [2:0] S_DRN2 = 3'd3;
   localparam logic [2:0] S_DRN3 = 3'd4;
   localparam logic [2:0] S_UPD  = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rv_ff, rv_in;
   logic       lastout_ff, lastout_in;

   wire take = req_valid && req_ready;
   wire out_free = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rv_in = rv_ff && !rsp_ready;
      lastout_in = lastout_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (req.command)
                  CMD_CLEAR: cmd.clear = 1'b1;
                  CMD_EMIT: begin
                     cmd.emit_start = 1'b1;
                     lastout_in = 1'b0;
                     state_in = S_EMIT;
                  end
                  default: begin
                     cmd.store_elem = 1'b1;
                     if (sts.left_done) begin
                        cmd.srch_start = 1'b1;
                        state_in = S_SRCH;
                     end
                  end
               endcase
            end
         end
         S_SRCH: begin
            cmd.srch_step = 1'b1;
            if (sts.srch_last) state_in = S_DRN1;
         end
         S_DRN1: state_in = S_DRN2;
         S_DRN2: state_in = S_DRN3;
         S_DRN3: state_in = S_UPD;
         S_UPD: begin
            cmd.update = 1'b1;
            state_in = S_IDLE;
         end
         S_EMIT: begin
            if (out_free) begin
               if (lastout_ff) state_in = S_IDLE;
               else begin
                  cmd.emit_load = 1'b1;
                  rv_in = 1'b1;
                  lastout_in = sts.emit_last;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; lastout_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; lastout_ff <= lastout_in;
      end
   end
endmodule

// ===== src/descriptor_match_best_k_top.sv =====
// Search: a completing left descriptor starts a search over the stored right descriptors,
//   skipping excluded or absent candidates, then drains and updates the kept list.
// Throughput: the search reads one right-store element per cycle; no request is taken until it ends.
// Emit: KEEP_PAIRS transactions, one per cycle when the sink is ready.
// Reset: synchronous, clears counters and kept list; the stores stay unwritten.
// ----------------------------------------------------------------------------
// descriptor_match_best_k_top
// Brute-force SSD matcher keeping the best pairs.
// ----------------------------------------------------------------------------
module descriptor_match_best_k_top import dmbk_pkg::*; #(
   parameter int DESC_LEN   = DESC_LEN_DEF,
   parameter int KEEP_PAIRS = KEEP_PAIRS_DEF,
   parameter int MAX_RIGHT  = MAX_RIGHT_DEF
) (
   input logic clock,
   input logic reset,
   dmbk_if.sink   req,
   dmbk_if.source rsp
);
   cmd_type cmd;
   sts_type sts;
   rsp_type rsp_data;

   dmbk_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd(cmd), .sts(sts));

   dmbk_datapath #(.DESC_LEN(DESC_LEN), .KEEP_PAIRS(KEEP_PAIRS),
                   .MAX_RIGHT(MAX_RIGHT)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req(req.data), .rsp(rsp_data));

   assign rsp.data = rsp_data;
endmodule

// ===== src/dmbk_checker.sv =====
// ----------------------------------------------------------------------------
// dmbk_checker
// Port-level checks on the matcher's handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dmbk_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_final
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   `CHK_IMPL(a_no_req_while_out, clock, reset, rsp_valid, !req_ready, "req taken during emit")
   `CHK_NEXT(a_emit_ends, clock, reset, rsp_valid && rsp_ready && rsp_final, !rsp_valid, "extra rsp")
endmodule

bind descriptor_match_best_k_top dmbk_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_final(rsp.data.final_pair));

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the best-k descriptor matcher against a predictor of the kept pair
// list. Right and left descriptors are streamed element by element under
// random idling on both channels. Every emitted slot is compared with the
// predicted slot.
// ----------------------------------------------------------------------------
module testbench;
   import dmbk_pkg::*;

   localparam int DL      = DESC_LEN_DEF;
   localparam int KP      = KEEP_PAIRS_DEF;
   localparam int MR      = MAX_RIGHT_DEF;
   localparam int LIMIT   = 200000;
   localparam int HOLD_LEN = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dmbk_if #(.payload_type(req_type)) req_ch ();
   dmbk_if #(.payload_type(rsp_type)) rsp_ch ();

   descriptor_match_best_k_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [ELEM_W-1:0] right_mem [0:MR*DL-1];
   logic [ELEM_W-1:0] left_buf [0:DL-1];
   logic [LEFT_W-1:0] kept_left [0:KP-1];
   logic [RNUM_W-1:0] kept_right [0:KP-1];
   logic [DIST_W-1:0] kept_dist [0:KP-1];
   int unsigned kept_count, right_count, position;
   logic [LEFT_W-1:0] left_count;

   rsp_type pair_q [$];
   logic [ELEM_W-1:0] bank [0:15][0:DL-1];

   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int errors = 0;
   int checked = 0;
   int sent = 0;
   int lefts_done = 0;
   int cycles = 0;

   function automatic void clear_model();
      for (int k = 0; k < KP; k++) begin
         kept_left[k] = '0;
         kept_right[k] = '0;
         kept_dist[k] = '0;
      end
      kept_count = 0;
      right_count = 0;
      left_count = '0;
      position = 0;
   endfunction

   function automatic bit is_kept(int unsigned r);
      for (int k = 0; k < kept_count; k++)
         if (kept_right[k] == r) return 1'b1;
      return 1'b0;
   endfunction

   // nearest non-excluded right descriptor, then update the kept list
   function automatic void match_left();
      bit found;
      int unsigned best, best_d, d, m;
      int diff;
      found = 1'b0;
      best = 0;
      best_d = 0;
      for (int unsigned j = 0; j < right_count; j++) begin
         if (is_kept(j)) continue;
         d = 0;
         for (int i = 0; i < DL; i++) begin
            diff = int'(left_buf[i]) - int'(right_mem[j*DL+i]);
            d += diff * diff;
         end
         if (d > DIST_MAX) d = DIST_MAX;
         if (!found || d < best_d) begin
            found = 1'b1;
            best = j;
            best_d = d;
         end
      end
      if (found) begin
         if (kept_count < KP) begin
            kept_left[kept_count] = left_count;
            kept_right[kept_count] = best[RNUM_W-1:0];
            kept_dist[kept_count] = best_d[DIST_W-1:0];
            kept_count++;
         end else begin
            m = 0;
            for (int k = 1; k < KP; k++)
               if (kept_dist[k] > kept_dist[m]) m = k;
            if (best_d < kept_dist[m]) begin
               kept_left[m] = left_count;
               kept_right[m] = best[RNUM_W-1:0];
               kept_dist[m] = best_d[DIST_W-1:0];
            end
         end
      end
      left_count++;
      lefts_done++;
   endfunction

   function automatic void predict_pairs(req_type item);
      rsp_type p;
      if (position >= DL) position = 0;
      case (item.command)
         CMD_RIGHT: begin
            if (right_count < MR) begin
               right_mem[right_count*DL+position] = item.element_value;
               position++;
               if (position >= DL) begin
                  position = 0;
                  right_count++;
               end
            end
         end
         CMD_LEFT: begin
            left_buf[position] = item.element_value;
            position++;
            if (position >= DL) begin
               position = 0;
               match_left();
            end
         end
         CMD_CLEAR: clear_model();
         default: begin
            for (int k = 0; k < KP; k++) begin
               p.pair_valid = (k < kept_count);
               p.left_number = p.pair_valid ? kept_left[k] : '0;
               p.right_number = p.pair_valid ? kept_right[k] : '0;
               p.distance = p.pair_valid ? kept_dist[k] : '0;
               p.final_pair = (k == KP - 1);
               pair_q.push_back(p);
            end
         end
      endcase
   endfunction

   // watch accepted transactions on both channels
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: errors");
         $finish;
      end
      if (!reset && req_ch.valid && req_ch.ready) predict_pairs(req_ch.data);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pair_q.size() == 0) begin
            $error("unexpected pair transaction");
            errors++;
         end else begin
            rsp_type e;
            e = pair_q.pop_front();
            checked++;
            if (rsp_ch.data.left_number !== e.left_number) begin
               $error("left_number: expected %0d, got %0d", e.left_number,
                      rsp_ch.data.left_number);
               errors++;
            end
            if (rsp_ch.data.right_number !== e.right_number) begin
               $error("right_number: expected %0d, got %0d", e.right_number,
                      rsp_ch.data.right_number);
               errors++;
            end
            if (rsp_ch.data.distance !== e.distance) begin
               $error("distance: expected %0d, got %0d", e.distance,
                      rsp_ch.data.distance);
               errors++;
            end
            if (rsp_ch.data.pair_valid !== e.pair_valid) begin
               $error("pair_valid: expected %0d, got %0d", e.pair_valid,
                      rsp_ch.data.pair_valid);
               errors++;
            end
            if (rsp_ch.data.final_pair !== e.final_pair) begin
               $error("final_pair: expected %0d, got %0d", e.final_pair,
                      rsp_ch.data.final_pair);
               errors++;
            end
         end
      end
   end

   // result side: random stalls, plus a long hold when requested
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= HOLD_LEN;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_element(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] val);
      req_type item;
      item.command = cmd;
      item.element_value = val;
      if ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= item;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic send_desc(input logic [CMD_W-1:0] cmd, input int slot);
      for (int i = 0; i < DL; i++) send_element(cmd, bank[slot][i]);
   endtask

   // kind 0: all zero, 1: all ones, 2: random, 3: near another bank slot
   task automatic make_desc(input int slot, input int kind, input int near);
      int v;
      for (int i = 0; i < DL; i++) begin
         case (kind)
            0: bank[slot][i] = 8'h00;
            1: bank[slot][i] = 8'hFF;
            2: bank[slot][i] = 8'($urandom);
            default: begin
               v = int'(bank[near][i]) + $urandom_range(6) - 3;
               bank[slot][i] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : 8'(v);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pair_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_list();
      send_element(CMD_CLEAR, 8'h00);
      send_element(CMD_EMIT, 8'h00);
   endtask

   // one stored right descriptor and a nearby left descriptor
   task automatic test_single_match();
      make_desc(0, 2, 0);
      make_desc(15, 3, 0);
      send_desc(CMD_RIGHT, 0);
      send_desc(CMD_LEFT, 15);
      send_element(CMD_EMIT, 8'h00);
   endtask

   // hold the result side off while the sender keeps offering items
   task automatic test_backpressure();
      hold_ticket++;
      repeat (3) send_element(CMD_EMIT, 8'h00);
   endtask

   // part of a left descriptor and an emit, then clear and emit again
   task automatic test_partial_clear();
      repeat ($urandom_range(8, 2)) send_element(CMD_LEFT, 8'($urandom));
      send_element(CMD_EMIT, 8'h00);
      send_element(CMD_CLEAR, 8'h00);
      send_element(CMD_EMIT, 8'h00);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      clear_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct = 23;
      recv_stall_pct = 86;
      test_empty_list();
      test_single_match();
      send_gap_pct = 86;
      recv_stall_pct = 23;
      test_backpressure();
      send_gap_pct = 0;
      recv_stall_pct = 0;
      test_partial_clear();

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d element transactions, %0d left descriptors matched,",
               sent, lefts_done);
      $display("%0d pair slots checked, with a long result stall and a clear", checked);
      if (errors == 0 && pair_q.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
